[rtl/llt_pkg.sv]
// ----------------------------------------------------------------------------
// llt_pkg
// Shared types, token kinds and character classes for the lambda tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package llt_pkg;

    localparam int POS_BITS = 16;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef logic [POS_BITS-1:0] t_pos;

    localparam t_pos POS_MAX = {POS_BITS{1'b1}};

    localparam logic [4:0] K_EOF    = 5'd0;
    localparam logic [4:0] K_LAMBDA = 5'd1;
    localparam logic [4:0] K_IDENT  = 5'd2;
    localparam logic [4:0] K_NUMBER = 5'd3;
    localparam logic [4:0] K_LPAREN = 5'd4;
    localparam logic [4:0] K_RPAREN = 5'd5;
    localparam logic [4:0] K_DOT    = 5'd6;
    localparam logic [4:0] K_PLUS   = 5'd7;
    localparam logic [4:0] K_MINUS  = 5'd8;
    localparam logic [4:0] K_STAR   = 5'd9;
    localparam logic [4:0] K_SLASH  = 5'd10;
    localparam logic [4:0] K_CARET  = 5'd11;
    localparam logic [4:0] K_AND    = 5'd12;
    localparam logic [4:0] K_OR     = 5'd13;
    localparam logic [4:0] K_EQ     = 5'd14;
    localparam logic [4:0] K_NE     = 5'd15;
    localparam logic [4:0] K_NOT    = 5'd16;
    localparam logic [4:0] K_ERROR  = 5'd17;

    localparam logic [2:0] M_NONE   = 3'd0;
    localparam logic [2:0] M_IDENT  = 3'd1;
    localparam logic [2:0] M_NUMBER = 3'd2;
    localparam logic [2:0] M_AMP    = 3'd3;
    localparam logic [2:0] M_BAR    = 3'd4;
    localparam logic [2:0] M_EQ     = 3'd5;
    localparam logic [2:0] M_BANG   = 3'd6;

    localparam logic [7:0] CH_EOT   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } t_token;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_USCORE;
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // single-character operator kinds; K_EOF means no match
    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        k = K_EOF;
        case (c)
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h2E:   k = K_DOT;
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h5E:   k = K_CARET;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    // clamp a position-sized value (one guard bit) to 16 bits
    function automatic logic [15:0] sat16(input logic [POS_BITS:0] v);
        logic [POS_BITS+16:0] w;
        w = {16'b0, v};
        if (w > (POS_BITS+17)'(17'h0FFFF)) begin
            return 16'hFFFF;
        end
        return 16'(v);
    endfunction

endpackage

`default_nettype wire

[rtl/lambda_language_tokenizer.sv]
// ----------------------------------------------------------------------------
// lambda_language_tokenizer
// Streaming byte scanner for a small lambda-calculus language.
// ----------------------------------------------------------------------------
// Input channel: one source byte per beat on i_char_code (i_valid/o_ready).
// A byte of 0 ends the text: any pending token is flushed, an EOF token
// follows, and the scan state returns to its reset values.
// Output channel: one token per beat (o_valid/i_ready) with kind, start
// offset, length, line number and last_of_run, which marks the final token
// caused by one input byte. A byte causes zero, one or two tokens.
// Each byte is classified and the scan state updated in the cycle it is
// accepted; its tokens are written into a 4-entry result queue, from which
// the output port reads them in order. One byte is accepted per cycle
// while the queue has room for two tokens; throughput is one byte per cycle
// as long as tokens drain, and two-token bytes are bounded by the one-token
// per cycle output port.
// Reset (synchronous, active low) empties the queue, clears the pending
// token, sets offset to 0 and line to 1. When the receiver stalls, the queue
// fills and o_ready drops until space for two tokens is free again.
// ----------------------------------------------------------------------------
`default_nettype none

module lambda_language_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_code,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_token_kind,
    output logic [15:0]      o_start_offset,
    output logic [15:0]      o_token_length,
    output logic [15:0]      o_line_number,
    output logic             o_last_of_run
);

    logic [2:0]     r_mode,  n_mode;
    llt_pkg::t_pos  r_start, n_start;
    llt_pkg::t_pos  r_off,   n_off;
    llt_pkg::t_pos  r_line,  n_line;

    llt_pkg::t_token r_q [llt_pkg::QDEPTH];
    logic [llt_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [llt_pkg::QCNT_W-1:0] r_cnt;

    logic            acc, pop;
    logic            res0_v, res1_v;
    llt_pkg::t_token res0, res1;

    logic [7:0]          c;
    logic [4:0]          opk;
    llt_pkg::t_pos       run;
    logic [llt_pkg::POS_BITS:0] len_p1;
    logic [llt_pkg::POS_BITS:0] pair_len;
    logic                done;
    logic [15:0]         line16;

    assign c       = i_char_code;
    assign o_ready = r_cnt <= llt_pkg::QCNT_W'(llt_pkg::QDEPTH - 2);
    assign acc     = i_valid && o_ready;
    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && i_ready;

    assign opk      = llt_pkg::op_kind(c);
    assign run      = (r_off >= r_start) ? (r_off - r_start) : '0;
    assign len_p1   = {1'b0, run} + (llt_pkg::POS_BITS+1)'(1);
    assign pair_len = len_p1[llt_pkg::POS_BITS] ? {1'b0, llt_pkg::POS_MAX} : len_p1;
    assign line16   = llt_pkg::sat16({1'b0, r_line});

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_off   = (r_off < llt_pkg::POS_MAX) ? r_off + llt_pkg::t_pos'(1) : r_off;
        n_line  = r_line;
        res0_v  = 1'b0;
        res1_v  = 1'b0;
        res0    = '{kind: llt_pkg::K_ERROR, start: llt_pkg::sat16({1'b0, r_start}),
                    len: 16'd1, line: line16, last: 1'b0};
        res1    = '{kind: llt_pkg::K_ERROR, start: llt_pkg::sat16({1'b0, r_off}),
                    len: 16'd1, line: line16, last: 1'b1};
        done    = 1'b0;

        case (r_mode)
            llt_pkg::M_IDENT:  done = llt_pkg::is_letter(c) || llt_pkg::is_numeral(c);
            llt_pkg::M_NUMBER: done = llt_pkg::is_numeral(c);
            llt_pkg::M_AMP:    done = c == llt_pkg::CH_AMP;
            llt_pkg::M_BAR:    done = c == llt_pkg::CH_BAR;
            llt_pkg::M_EQ,
            llt_pkg::M_BANG:   done = c == llt_pkg::CH_EQ;
            default:           done = 1'b0;
        endcase
        if (c == llt_pkg::CH_EOT) begin
            done = 1'b0;
        end

        // flush of the pending token, or a completed pair
        case (r_mode)
            llt_pkg::M_IDENT: begin
                res0.kind = llt_pkg::K_IDENT;
                res0.len  = llt_pkg::sat16({1'b0, run});
            end
            llt_pkg::M_NUMBER: begin
                res0.kind = llt_pkg::K_NUMBER;
                res0.len  = llt_pkg::sat16({1'b0, run});
            end
            llt_pkg::M_AMP: res0.kind = done ? llt_pkg::K_AND : llt_pkg::K_ERROR;
            llt_pkg::M_BAR: res0.kind = done ? llt_pkg::K_OR  : llt_pkg::K_ERROR;
            llt_pkg::M_EQ:  res0.kind = done ? llt_pkg::K_EQ  : llt_pkg::K_ERROR;
            llt_pkg::M_BANG: res0.kind = done ? llt_pkg::K_NE : llt_pkg::K_NOT;
            default:        res0.kind = llt_pkg::K_ERROR;
        endcase
        if (done && r_mode >= llt_pkg::M_AMP) begin
            res0.len = llt_pkg::sat16(pair_len);
        end

        if (c == llt_pkg::CH_EOT) begin
            res0_v     = (r_mode != llt_pkg::M_NONE) && (r_mode <= llt_pkg::M_BANG);
            res1_v     = 1'b1;
            res1.kind  = llt_pkg::K_EOF;
            res1.len   = 16'd0;
            n_mode     = llt_pkg::M_NONE;
            n_start    = '0;
            n_off      = '0;
            n_line     = llt_pkg::t_pos'(1);
        end else if (done) begin
            if (r_mode >= llt_pkg::M_AMP) begin
                res0_v = 1'b1;
                n_mode = llt_pkg::M_NONE;
            end
        end else begin
            res0_v = (r_mode != llt_pkg::M_NONE) && (r_mode <= llt_pkg::M_BANG);
            n_mode = llt_pkg::M_NONE;
            if (c == llt_pkg::CH_SPACE || c == llt_pkg::CH_TAB || c == llt_pkg::CH_CR) begin
                n_mode = llt_pkg::M_NONE;
            end else if (c == llt_pkg::CH_LF) begin
                if (r_line < llt_pkg::POS_MAX) begin
                    n_line = r_line + llt_pkg::t_pos'(1);
                end
            end else if (opk != llt_pkg::K_EOF) begin
                res1_v    = 1'b1;
                res1.kind = opk;
            end else if (c == llt_pkg::CH_AMP) begin
                n_mode  = llt_pkg::M_AMP;
                n_start = r_off;
            end else if (c == llt_pkg::CH_BAR) begin
                n_mode  = llt_pkg::M_BAR;
                n_start = r_off;
            end else if (c == llt_pkg::CH_EQ) begin
                n_mode  = llt_pkg::M_EQ;
                n_start = r_off;
            end else if (c == llt_pkg::CH_BANG) begin
                n_mode  = llt_pkg::M_BANG;
                n_start = r_off;
            end else if (c == llt_pkg::CH_L) begin
                res1_v    = 1'b1;
                res1.kind = llt_pkg::K_LAMBDA;
            end else if (llt_pkg::is_letter(c)) begin
                n_mode  = llt_pkg::M_IDENT;
                n_start = r_off;
            end else if (llt_pkg::is_numeral(c)) begin
                n_mode  = llt_pkg::M_NUMBER;
                n_start = r_off;
            end else begin
                res1_v = 1'b1;
            end
        end
        res0.last = !res1_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= llt_pkg::M_NONE;
            r_start <= '0;
            r_off   <= '0;
            r_line  <= llt_pkg::t_pos'(1);
        end else if (acc) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_off   <= n_off;
            r_line  <= n_line;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (acc && res0_v) begin
            r_q[r_wp] <= res0;
        end
        if (acc && res1_v) begin
            r_q[r_wp + llt_pkg::QPTR_W'(res0_v)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (acc) begin
                r_wp <= r_wp + llt_pkg::QPTR_W'(res0_v) + llt_pkg::QPTR_W'(res1_v);
            end
            if (pop) begin
                r_rp <= r_rp + llt_pkg::QPTR_W'(1);
            end
            r_cnt <= r_cnt
                   + (acc ? llt_pkg::QCNT_W'(res0_v) + llt_pkg::QCNT_W'(res1_v)
                          : llt_pkg::QCNT_W'(0))
                   - llt_pkg::QCNT_W'(pop);
        end
    end

    assign o_token_kind   = r_q[r_rp].kind;
    assign o_start_offset = r_q[r_rp].start;
    assign o_token_length = r_q[r_rp].len;
    assign o_line_number  = r_q[r_rp].line;
    assign o_last_of_run  = r_q[r_rp].last;

endmodule

`default_nettype wire

[rtl/llt_checker.sv]
// ----------------------------------------------------------------------------
// llt_checker
// Port-level checks for the lambda tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module llt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [7:0]  i_char_code,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [4:0]  o_token_kind,
    input wire logic [15:0] o_start_offset,
    input wire logic [15:0] o_token_length,
    input wire logic [15:0] o_line_number,
    input wire logic        o_last_of_run
);

    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == llt_pkg::K_EOF |-> o_token_length == 16'd0 && o_last_of_run)
        else $error("eof token must have zero length and end its run");

    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == llt_pkg::K_LAMBDA || o_token_kind == llt_pkg::K_NOT ||
                    o_token_kind == llt_pkg::K_ERROR  || o_token_kind == llt_pkg::K_LPAREN ||
                    o_token_kind == llt_pkg::K_CARET) |-> o_token_length == 16'd1)
        else $error("single-character token with length other than one");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_line_number != 16'd0)
        else $error("line number zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind) && $stable(o_start_offset))
        else $error("stalled output beat changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_char_code))
        else $error("waiting input beat changed");

endmodule

bind lambda_language_tokenizer llt_checker u_llt_checker (.*);

`default_nettype wire
